>>> sv/fftv_pkg.sv
package fftv_pkg;

  localparam int MAX_FIELD_LEN = 32;
  localparam int LEN_W         = 6;
  localparam int PEND_DEPTH    = 32;
  localparam int PEND_AW       = 5;
  localparam int CNT_W         = 6;

  localparam logic       KIND_DATA   = 1'b0;
  localparam logic       KIND_END    = 1'b1;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_OVERLONG = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] field_mode;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] out_byte;
    logic [1:0] field_status;
    logic       end_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    LD_NONE,
    LD_IN_BYTE,
    LD_IN_END,
    LD_HELD_BYTE,
    LD_HELD_END,
    LD_PEND
  } ld_sel_e;

  typedef struct packed {
    logic    accept;
    logic    rd_en;
    logic    idx_inc;
    ld_sel_e ld_sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic plan_flush;
    logic plan_byte;
    logic plan_end;
    logic out_free;
    logic flush_last;
    logic held_last;
  } dp_stat_t;

endpackage

>>> sv/fftv_ctrl.sv
module fftv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fftv_pkg::dp_stat_t stat_i,
  output fftv_pkg::ctl_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_PEND = 3'd2;
  localparam logic [2:0] S_BYTE = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.accept  = 1'b0;
    cmd_o.rd_en   = 1'b0;
    cmd_o.idx_inc = 1'b0;
    cmd_o.ld_sel  = fftv_pkg::LD_NONE;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = stat_i.out_free;
        cmd_o.accept = in_valid_i && stat_i.out_free;
        if (cmd_o.accept) begin
          if (stat_i.plan_flush) begin
            state_d = S_RD;
          end else if (stat_i.plan_byte) begin
            cmd_o.ld_sel = fftv_pkg::LD_IN_BYTE;
            if (stat_i.plan_end) begin
              state_d = S_END;
            end
          end else if (stat_i.plan_end) begin
            cmd_o.ld_sel = fftv_pkg::LD_IN_END;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_PEND;
      end
      S_PEND: begin
        if (stat_i.out_free) begin
          cmd_o.ld_sel  = fftv_pkg::LD_PEND;
          cmd_o.idx_inc = 1'b1;
          state_d       = stat_i.flush_last ? S_BYTE : S_RD;
        end
      end
      S_BYTE: begin
        if (stat_i.out_free) begin
          cmd_o.ld_sel = fftv_pkg::LD_HELD_BYTE;
          state_d      = stat_i.held_last ? S_END : S_IDLE;
        end
      end
      S_END: begin
        if (stat_i.out_free) begin
          cmd_o.ld_sel = fftv_pkg::LD_HELD_END;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/fftv_dpath.sv
module fftv_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fftv_pkg::in_item_t  in_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output fftv_pkg::out_item_t out_data_o,
  input  fftv_pkg::ctl_cmd_t  cmd_i,
  output fftv_pkg::dp_stat_t  stat_o
);

  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_ZERO = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  localparam logic [2:0] MODE_ANY   = 3'd0;
  localparam logic [2:0] MODE_ALPHA = 3'd1;
  localparam logic [2:0] MODE_NUM   = 3'd2;
  localparam logic [2:0] MODE_ALNUM = 3'd3;
  localparam logic [2:0] MODE_ZNUM  = 3'd4;

  localparam logic [7:0] CH_ZERO = 8'h30;

  logic [1:0]                  phase_q, phase_d;
  logic                        failed_q, failed_d;
  logic [fftv_pkg::CNT_W-1:0]  count_q;
  logic [fftv_pkg::LEN_W-1:0]  seen_q;
  logic [fftv_pkg::CNT_W-1:0]  flush_len_q;
  logic [fftv_pkg::CNT_W-1:0]  idx_q;
  logic [7:0]                  byte_q;
  logic                        last_q;
  logic [1:0]                  status_q, status_d;
  logic [7:0]                  rdata_q;
  logic                        out_valid_q;
  fftv_pkg::out_item_t         out_q;

  logic [7:0] mem [fftv_pkg::PEND_DEPTH];

  logic [7:0] c;
  logic [2:0] mode;
  logic       is_ws, is_dig, is_alp, cls_ok;
  logic       store, plan_flush, plan_byte, overlong;

  assign c    = in_data_i.data_byte;
  assign mode = in_data_i.field_mode;

  always_comb begin
    is_ws  = c inside {8'd32, [8'd9:8'd13]};
    is_dig = c inside {["0":"9"]};
    is_alp = c inside {["A":"Z"], ["a":"z"]};
    case (mode)
      MODE_ANY:   cls_ok = 1'b1;
      MODE_ALPHA: cls_ok = is_alp;
      MODE_NUM:   cls_ok = is_dig;
      MODE_ALNUM: cls_ok = is_alp || is_dig;
      MODE_ZNUM:  cls_ok = is_dig;
      default:    cls_ok = 1'b0;
    endcase
  end

  // judge the incoming byte against the current trim state
  always_comb begin
    store      = 1'b0;
    plan_flush = 1'b0;
    plan_byte  = 1'b0;
    phase_d    = phase_q;
    failed_d   = failed_q;
    if (!failed_q) begin
      if (is_ws) begin
        store = (phase_q != PH_LEAD) &&
                (count_q < fftv_pkg::CNT_W'(fftv_pkg::PEND_DEPTH));
      end else begin
        if (count_q != '0) begin
          if (mode == MODE_ANY) begin
            plan_flush = 1'b1;
          end else begin
            failed_d = 1'b1;
          end
        end
        if (!failed_d) begin
          if (mode == MODE_ZNUM && phase_q != PH_BODY && c == CH_ZERO) begin
            phase_d = PH_ZERO;
          end else if (cls_ok) begin
            plan_byte = 1'b1;
            phase_d   = PH_BODY;
          end else begin
            failed_d = 1'b1;
          end
        end
      end
    end
    overlong = seen_q >= fftv_pkg::LEN_W'(fftv_pkg::MAX_FIELD_LEN);
    if (overlong) begin
      status_d = fftv_pkg::ST_OVERLONG;
    end else if (failed_d) begin
      status_d = fftv_pkg::ST_MISMATCH;
    end else begin
      status_d = fftv_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEAD;
      failed_q <= 1'b0;
      count_q  <= '0;
      seen_q   <= '0;
      idx_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        idx_q <= '0;
        if (in_data_i.last_byte) begin
          phase_q  <= PH_LEAD;
          failed_q <= 1'b0;
          count_q  <= '0;
          seen_q   <= '0;
        end else begin
          phase_q  <= phase_d;
          failed_q <= failed_d;
          if (plan_flush) begin
            count_q <= '0;
          end else if (store) begin
            count_q <= count_q + 1'b1;
          end
          if (!overlong) begin
            seen_q <= seen_q + 1'b1;
          end
        end
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // hold what the later result steps need
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q      <= c;
      last_q      <= in_data_i.last_byte;
      status_q    <= status_d;
      flush_len_q <= count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && store) begin
      mem[count_q[fftv_pkg::PEND_AW-1:0]] <= c;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[idx_q[fftv_pkg::PEND_AW-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.ld_sel != fftv_pkg::LD_NONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.ld_sel)
      fftv_pkg::LD_IN_BYTE: begin
        out_q <= '{fftv_pkg::KIND_DATA, c, fftv_pkg::ST_OK, !in_data_i.last_byte};
      end
      fftv_pkg::LD_IN_END: begin
        out_q <= '{fftv_pkg::KIND_END, 8'd0, status_d, 1'b1};
      end
      fftv_pkg::LD_HELD_BYTE: begin
        out_q <= '{fftv_pkg::KIND_DATA, byte_q, fftv_pkg::ST_OK, !last_q};
      end
      fftv_pkg::LD_HELD_END: begin
        out_q <= '{fftv_pkg::KIND_END, 8'd0, status_q, 1'b1};
      end
      fftv_pkg::LD_PEND: begin
        out_q <= '{fftv_pkg::KIND_DATA, rdata_q, fftv_pkg::ST_OK, 1'b0};
      end
      default: begin
        out_q <= out_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.plan_flush = plan_flush;
  assign stat_o.plan_byte  = plan_byte;
  assign stat_o.plan_end   = in_data_i.last_byte;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.flush_last = (idx_q + 1'b1) == flush_len_q;
  assign stat_o.held_last  = last_q;

endmodule

>>> sv/fixed_field_trim_validate.sv
// A kept byte or an end status enters the output register as its byte is taken, except
// after a flush of held spaces or for an end status that follows a kept byte. Input is
// taken at one byte per cycle while the output drains, but is held off while such an
// end status goes out and while each held space is read from the pending memory and sent.
// Reset (rst_ni low, asynchronous): trim state, counters and output valid clear;
// the pending-space memory is not cleared.
module fixed_field_trim_validate (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fftv_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fftv_pkg::out_item_t out_data_o
);

  fftv_pkg::ctl_cmd_t cmd;
  fftv_pkg::dp_stat_t stat;

  fftv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fftv_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

>>> tb/fixed_field_trim_validate_checker.sv
`timescale 1ns / 1ps

package fftv_tb_pkg;

  typedef enum logic [2:0] {
    MODE_ANY,
    MODE_ALPHA,
    MODE_DIGIT,
    MODE_ALNUM,
    MODE_ZSTRIP,
    MODE_RSVD5,
    MODE_RSVD6,
    MODE_RSVD7
  } field_mode_e;

  localparam logic [7:0] SPACE_CH = 8'h20;
  localparam logic [7:0] ZERO_CH  = "0";

  function automatic bit is_space(logic [7:0] c);
    return c == SPACE_CH || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

endpackage

module fixed_field_trim_validate_checker
  import fftv_pkg::*;
  import fftv_tb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        trimmed_left_o
);

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_ZEROS,
    PH_BODY
  } trim_phase_e;

  trim_phase_e phase;
  bit          failed;
  bit          overlong;
  logic [7:0]  held_ws [PEND_DEPTH];
  int          held_cnt;
  int          seen;
  out_item_t   trimmed_q [$];

  function automatic bit byte_fits(logic [7:0] c, logic [2:0] mode);
    case (mode)
      MODE_ANY:                return 1'b1;
      MODE_ALPHA:              return is_alpha(c);
      MODE_DIGIT, MODE_ZSTRIP: return is_digit(c);
      MODE_ALNUM:              return is_alpha(c) || is_digit(c);
      default:                 return 1'b0;
    endcase
  endfunction

  function automatic void emit(logic kind, logic [7:0] b, logic [1:0] st);
    out_item_t item;
    item = '{result_kind: kind, out_byte: b, field_status: st, end_of_run: 1'b0};
    trimmed_q = {trimmed_q, item};
  endfunction

  task automatic trim_byte(input in_item_t req);
    int        first;
    out_item_t tail;
    first = trimmed_q.size();
    if (seen >= MAX_FIELD_LEN) overlong = 1'b1;
    else seen++;

    if (!failed) begin
      if (is_space(req.data_byte)) begin
        // hold whitespace after content; drop it once the store is full
        if (phase != PH_LEAD && held_cnt < PEND_DEPTH) begin
          held_ws[held_cnt] = req.data_byte;
          held_cnt++;
        end
      end else begin
        if (held_cnt > 0) begin
          if (req.field_mode == MODE_ANY) begin
            for (int i = 0; i < held_cnt; i++) emit(KIND_DATA, held_ws[i], ST_OK);
            held_cnt = 0;
          end else begin
            failed = 1'b1;
          end
        end
        if (!failed) begin
          if (req.field_mode == MODE_ZSTRIP && phase != PH_BODY &&
              req.data_byte == ZERO_CH) begin
            phase = PH_ZEROS;
          end else if (byte_fits(req.data_byte, req.field_mode)) begin
            emit(KIND_DATA, req.data_byte, ST_OK);
            phase = PH_BODY;
          end else begin
            failed = 1'b1;
          end
        end
      end
    end

    if (req.last_byte) begin
      emit(KIND_END, 8'h00, overlong ? ST_OVERLONG : (failed ? ST_MISMATCH : ST_OK));
      phase    = PH_LEAD;
      failed   = 1'b0;
      held_cnt = 0;
      seen     = 0;
      overlong = 1'b0;
    end

    if (trimmed_q.size() > first) begin
      tail = trimmed_q.pop_back();
      tail.end_of_run = 1'b1;
      trimmed_q = {trimmed_q, tail};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      phase          = PH_LEAD;
      failed         = 1'b0;
      overlong       = 1'b0;
      held_cnt       = 0;
      seen           = 0;
      trimmed_q.delete();
      fail_count_o   = 0;
      trimmed_left_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) trim_byte(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (trimmed_q.size() == 0) begin
          $display("%0t: unexpected result: kind %0d byte %02h status %0d last %0d", $time,
                   out_data_i.result_kind, out_data_i.out_byte, out_data_i.field_status,
                   out_data_i.end_of_run);
          fail_count_o++;
        end else begin
          want = trimmed_q.pop_front();
          if (out_data_i.result_kind !== want.result_kind ||
              out_data_i.out_byte !== want.out_byte ||
              out_data_i.field_status !== want.field_status ||
              out_data_i.end_of_run !== want.end_of_run) begin
            $display({"%0t: mismatch: expected kind %0d byte %02h status %0d last %0d,",
                      " got kind %0d byte %02h status %0d last %0d"},
                     $time, want.result_kind, want.out_byte, want.field_status,
                     want.end_of_run, out_data_i.result_kind, out_data_i.out_byte,
                     out_data_i.field_status, out_data_i.end_of_run);
            fail_count_o++;
          end
        end
      end
      trimmed_left_o = trimmed_q.size();
    end
  end

endmodule

>>> tb/fixed_field_trim_validate_tb.sv
`timescale 1ns / 1ps

module fixed_field_trim_validate_tb;
  import fftv_pkg::*;
  import fftv_tb_pkg::*;

  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES    = 100;
  localparam int RANDOM_BYTES    = 100;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int         fail_count;
  int         trimmed_left;
  int         bytes_sent;
  int         idle_pct;
  bit         hold_off_req;
  bit         hold_off_done;
  logic [7:0] field_q [$];
  logic [2:0] mode_q [$];

  fixed_field_trim_validate dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  fixed_field_trim_validate_checker trim_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .fail_count_o   (fail_count),
    .trimmed_left_o (trimmed_left)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("fixed_field_trim_validate test failed");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_space();
    int r;
    r = $urandom_range(0, 6);
    return (r > 4) ? SPACE_CH : 8'(9 + r);
  endfunction

  function automatic logic [7:0] rand_fit(logic [2:0] mode);
    logic [7:0] c;
    case (mode)
      MODE_ALPHA: c = 8'($urandom_range(0, 1) ? "A" : "a") + 8'($urandom_range(0, 25));
      MODE_DIGIT, MODE_ZSTRIP: c = ZERO_CH + 8'($urandom_range(0, 9));
      MODE_ALNUM: begin
        if ($urandom_range(0, 1)) c = ZERO_CH + 8'($urandom_range(0, 9));
        else c = 8'($urandom_range(0, 1) ? "A" : "a") + 8'($urandom_range(0, 25));
      end
      default: begin
        do c = 8'($urandom_range(0, 255)); while (is_space(c));
      end
    endcase
    return c;
  endfunction

  // punctuation and high bytes fail every class mode
  function automatic logic [7:0] rand_misfit();
    if ($urandom_range(0, 1)) return 8'($urandom_range(8'h21, 8'h2F));
    return 8'($urandom_range(8'h80, 8'hFF));
  endfunction

  task automatic add_byte(input logic [7:0] c, input logic [2:0] mode);
    field_q = {field_q, c};
    mode_q  = {mode_q, mode};
  endtask

  task automatic send_req(input logic [7:0] c, input logic [2:0] mode, input bit last);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: c, field_mode: mode, last_byte: last};
    do @(posedge clk_i); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_field();
    for (int i = 0; i < field_q.size(); i++)
      send_req(field_q[i], mode_q[i], i == field_q.size() - 1);
    field_q.delete();
    mode_q.delete();
  endtask

  task automatic build_clean(input logic [2:0] mode, input int body_len);
    repeat ($urandom_range(0, 3)) add_byte(rand_space(), mode);
    if (mode == MODE_ZSTRIP) repeat ($urandom_range(0, 3)) add_byte(ZERO_CH, mode);
    for (int i = 0; i < body_len; i++) begin
      if (mode == MODE_ANY && i > 0 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) add_byte(rand_space(), mode);
      add_byte(rand_fit(mode), mode);
    end
    repeat ($urandom_range(0, 2)) add_byte(rand_space(), mode);
  endtask

  initial begin : sink
    int span;
    bit ready_val;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        // long hold-off so the block fills up and stalls its input
        hold_off_done = 1'b1;
        ready_val     = 1'b0;
        span          = HOLD_OFF_CYCLES;
      end else if ($urandom_range(0, 9) < 4) begin
        ready_val = 1'b0;
        span      = pick_gap();
      end else begin
        ready_val = 1'b1;
        span      = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 8);
      end
      out_ready <= ready_val;
      repeat (span) @(posedge clk_i);
    end
  end

  initial begin
    int         pick;
    int         start;
    logic [2:0] m;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct = 20;

    // all-whitespace field
    add_byte(8'h09, MODE_ALPHA); add_byte(8'h0A, MODE_ALPHA); add_byte(8'h0D, MODE_ALPHA);
    send_field();
    // single blank byte
    add_byte(SPACE_CH, MODE_ANY);
    send_field();
    // zero-stripped mode, zeros only
    add_byte(ZERO_CH, MODE_ZSTRIP); add_byte(ZERO_CH, MODE_ZSTRIP);
    send_field();
    // leading zeros dropped, zero after the digit kept, trailing blank dropped
    add_byte(ZERO_CH, MODE_ZSTRIP); add_byte(ZERO_CH, MODE_ZSTRIP);
    add_byte("7", MODE_ZSTRIP); add_byte(ZERO_CH, MODE_ZSTRIP); add_byte(8'h0B, MODE_ZSTRIP);
    send_field();
    // interior whitespace flushed in any-byte mode, extreme byte values
    add_byte("a", MODE_ANY); add_byte(8'h0C, MODE_ANY); add_byte(SPACE_CH, MODE_ANY);
    add_byte(8'hFF, MODE_ANY); add_byte(8'h00, MODE_ANY); add_byte(SPACE_CH, MODE_ANY);
    send_field();
    // class failure after a kept byte
    add_byte("Q", MODE_ALPHA); add_byte("9", MODE_ALPHA); add_byte("z", MODE_ALPHA);
    send_field();
    // held whitespace followed by content in a class mode
    add_byte("a", MODE_ALNUM); add_byte(SPACE_CH, MODE_ALNUM); add_byte("b", MODE_ALNUM);
    send_field();
    // reserved mode rejects any content
    add_byte("5", MODE_RSVD7);
    send_field();
    // mode changes within a field
    add_byte("1", MODE_DIGIT); add_byte("k", MODE_ALPHA);
    send_field();

    hold_off_req = 1'b1;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 25;
        default: idle_pct = 60;
      endcase
      m = 3'($urandom_range(MODE_ANY, MODE_ZSTRIP));
      if (pick < 65) begin
        build_clean(m, $urandom_range(1, 6));
      end else if (pick < 75) begin
        if (m == MODE_ANY) m = MODE_ALNUM;
        build_clean(m, $urandom_range(1, 3));
        add_byte(rand_misfit(), m);
        add_byte(rand_fit(m), m);
      end else if (pick < 82) begin
        m = 3'($urandom_range(MODE_ALPHA, MODE_ZSTRIP));
        add_byte(rand_fit(m), m);
        repeat ($urandom_range(1, 2)) add_byte(rand_space(), m);
        add_byte(rand_fit(m), m);
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 3) == 0) add_byte(rand_space(), 3'($urandom_range(0, 7)));
          else add_byte(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
        end
      end else if (pick < 96) begin
        build_clean(m, $urandom_range(MAX_FIELD_LEN + 1, MAX_FIELD_LEN + 6));
      end else begin
        // more interior blanks than the store holds
        add_byte("x", MODE_ANY);
        repeat (PEND_DEPTH + 2) add_byte(rand_space(), MODE_ANY);
        add_byte("y", MODE_ANY);
      end
      send_field();
    end
    in_valid <= 1'b0;

    // sample the checker away from the rising edge
    @(negedge clk_i);
    while (trimmed_left != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("fixed_field_trim_validate test passed");
    end else begin
      $display("fixed_field_trim_validate test failed");
    end
    $finish;
  end

endmodule
